// File: design/lsim_pkg.sv
`timescale 1ns / 1ps

package lsim_pkg;

  localparam int unsigned DIV_BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES         = 16 / DIV_BITS_PER_STAGE;
  // input reg, check stage, divider stages, output reg
  localparam int unsigned LATENCY            = DIV_STAGES + 3;

  typedef enum logic [2:0] {
    REG_SEGMENT_MODE   = 3'd0,
    REG_STRIP_START    = 3'd1,
    REG_SEGMENT_LENGTH = 3'd2,
    REG_REVERSE_ORDER  = 3'd3,
    REG_REGION_LEFT    = 3'd4,
    REG_REGION_TOP     = 3'd5,
    REG_REGION_COLS    = 3'd6,
    REG_REGION_ROWS    = 3'd7
  } reg_idx_t;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_STRIP  = 2'd1;
  localparam logic [1:0] MODE_MATRIX = 2'd2;

  typedef struct packed {
    logic [15:0] pixel_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        to_matrix;
    logic [15:0] strip_address;
    logic [15:0] column;
    logic [15:0] row;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [15:0] logical;
    logic [15:0] rem;
    logic [15:0] quo;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } div_stage_t;

endpackage

// File: design/led_segment_index_mapper_unit.sv
`timescale 1ns / 1ps

// channel   direction  ports                                  handshake
// request   in         start, busy, in_req                    start && !busy
// result    out        out_strobe, out_res                    out_strobe, one cycle
// config    in         psel, penable, pwrite, paddr, pwdata,  psel && penable && pwrite
//                      prdata, pready
//
// one request per cycle while busy is low; each result passes through the
// input register, range check, eight radix-4 divider stages and output register
// busy is high during reset and in the first cycle after it; no other cycle refuses a request
// synchronous active-low reset clears the config registers and all stage valids
// the receiver cannot stall, so the pipeline never holds

module led_segment_index_mapper_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lsim_pkg::req_t       in_req,
  output logic                 out_strobe,
  output lsim_pkg::res_t       out_res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [1:0]  segment_mode_r;
  logic [15:0] strip_start_r;
  logic [15:0] segment_length_r;
  logic        reverse_order_r;
  logic [15:0] region_left_r;
  logic [15:0] region_top_r;
  logic [15:0] region_cols_r;
  logic [15:0] region_rows_r;
  logic        busy_r;
  logic        cfg_we;

  logic           s1_valid_r;
  lsim_pkg::req_t s1_req_r;

  lsim_pkg::div_stage_t div_r   [0:lsim_pkg::DIV_STAGES];
  lsim_pkg::div_stage_t div_nxt [0:lsim_pkg::DIV_STAGES];
  lsim_pkg::div_stage_t fin;

  lsim_pkg::res_t out_res_r;
  lsim_pkg::res_t out_res_nxt;
  logic           out_strobe_r;

  assign pready = 1'b1;
  assign busy   = busy_r;
  assign cfg_we = psel && penable && pwrite && pready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_mode_r   <= lsim_pkg::MODE_NONE;
      strip_start_r    <= '0;
      segment_length_r <= '0;
      reverse_order_r  <= 1'b0;
      region_left_r    <= '0;
      region_top_r     <= '0;
      region_cols_r    <= '0;
      region_rows_r    <= '0;
    end else if (cfg_we) begin
      case (lsim_pkg::reg_idx_t'(paddr[4:2]))
        lsim_pkg::REG_SEGMENT_MODE:   segment_mode_r   <= pwdata[1:0];
        lsim_pkg::REG_STRIP_START:    strip_start_r    <= pwdata[15:0];
        lsim_pkg::REG_SEGMENT_LENGTH: segment_length_r <= pwdata[15:0];
        lsim_pkg::REG_REVERSE_ORDER:  reverse_order_r  <= pwdata[0];
        lsim_pkg::REG_REGION_LEFT:    region_left_r    <= pwdata[15:0];
        lsim_pkg::REG_REGION_TOP:     region_top_r     <= pwdata[15:0];
        lsim_pkg::REG_REGION_COLS:    region_cols_r    <= pwdata[15:0];
        lsim_pkg::REG_REGION_ROWS:    region_rows_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lsim_pkg::reg_idx_t'(paddr[4:2]))
      lsim_pkg::REG_SEGMENT_MODE:   prdata = {30'd0, segment_mode_r};
      lsim_pkg::REG_STRIP_START:    prdata = {16'd0, strip_start_r};
      lsim_pkg::REG_SEGMENT_LENGTH: prdata = {16'd0, segment_length_r};
      lsim_pkg::REG_REVERSE_ORDER:  prdata = {31'd0, reverse_order_r};
      lsim_pkg::REG_REGION_LEFT:    prdata = {16'd0, region_left_r};
      lsim_pkg::REG_REGION_TOP:     prdata = {16'd0, region_top_r};
      lsim_pkg::REG_REGION_COLS:    prdata = {16'd0, region_cols_r};
      lsim_pkg::REG_REGION_ROWS:    prdata = {16'd0, region_rows_r};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    s1_req_r <= in_req;
  end

  // range check, logical index, divider stages
  always_comb begin
    lsim_pkg::div_stage_t cur;
    logic [16:0]          sh;
    logic                 mode_ok;

    mode_ok = (segment_mode_r == lsim_pkg::MODE_STRIP) ||
              (segment_mode_r == lsim_pkg::MODE_MATRIX);
    div_nxt[0].valid   = s1_valid_r;
    div_nxt[0].ok      = mode_ok && (s1_req_r.pixel_index < segment_length_r);
    div_nxt[0].logical = reverse_order_r ?
                         (segment_length_r - 16'd1 - s1_req_r.pixel_index) :
                         s1_req_r.pixel_index;
    div_nxt[0].rem     = '0;
    div_nxt[0].quo     = div_nxt[0].logical;
    div_nxt[0].red     = s1_req_r.red_in;
    div_nxt[0].green   = s1_req_r.green_in;
    div_nxt[0].blue    = s1_req_r.blue_in;

    for (int s = 1; s <= lsim_pkg::DIV_STAGES; s++) begin
      cur = div_r[s-1];
      for (int b = 0; b < lsim_pkg::DIV_BITS_PER_STAGE; b++) begin
        sh = {cur.rem, cur.quo[15]};
        if (sh >= {1'b0, region_cols_r}) begin
          sh      = sh - {1'b0, region_cols_r};
          cur.quo = {cur.quo[14:0], 1'b1};
        end else begin
          cur.quo = {cur.quo[14:0], 1'b0};
        end
        cur.rem = sh[15:0];
      end
      div_nxt[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= lsim_pkg::DIV_STAGES; s++) begin
      if (!rst_n) begin
        div_r[s] <= '0;
      end else begin
        div_r[s] <= div_nxt[s];
      end
    end
  end

  // address build
  assign fin = div_r[lsim_pkg::DIV_STAGES];

  always_comb begin
    out_res_nxt           = '0;
    out_res_nxt.red_out   = fin.red;
    out_res_nxt.green_out = fin.green;
    out_res_nxt.blue_out  = fin.blue;
    if (fin.ok) begin
      if (segment_mode_r == lsim_pkg::MODE_STRIP) begin
        out_res_nxt.accepted      = 1'b1;
        out_res_nxt.strip_address = strip_start_r + fin.logical;
      end else if (region_cols_r != 16'd0 && region_rows_r != 16'd0) begin
        out_res_nxt.accepted  = 1'b1;
        out_res_nxt.to_matrix = 1'b1;
        out_res_nxt.column    = region_left_r + fin.rem;
        out_res_nxt.row       = region_top_r + fin.quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= fin.valid;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(lsim_pkg::LATENCY) out_strobe)
    else $error("request did not produce a result at the pipeline latency");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_res.accepted) |->
      (!out_res.to_matrix && out_res.strip_address == 16'd0 &&
       out_res.column == 16'd0 && out_res.row == 16'd0))
    else $error("rejected result carries a nonzero address");

  a_matrix_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.to_matrix) |-> out_res.accepted)
    else $error("matrix flag set on a rejected result");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fin.valid && region_cols_r != 16'd0) |-> (fin.rem < region_cols_r))
    else $error("divider remainder not below the region width");

endmodule
